### sv/mcps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcps_pkg
// Widths, limits and state type shared by the partition search unit.
// ----------------------------------------------------------------------------
package mcps_pkg;

    localparam int MAX_ITEMS     = 1024;
    localparam int WEIGHT_BITS   = 16;
    localparam int DAY_BITS      = 11;
    localparam int CAP_BITS      = 26;
    localparam int ADDR_BITS     = $clog2(MAX_ITEMS);
    localparam int CNT_BITS      = $clog2(MAX_ITEMS + 1);
    localparam int NUM_BITS      = CAP_BITS + 1;
    localparam int STEP_BITS     = $clog2(NUM_BITS);
    localparam int IN_DATA_BITS  = ((WEIGHT_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((CAP_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PREP,
        ST_DIV,
        ST_BOUND,
        ST_MID,
        ST_SCAN,
        ST_OUT
    } state_t;

endpackage

### sv/min_capacity_partition_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_capacity_partition_search_unit
// Stores a run of weights, then binary-searches the smallest group capacity
// for which a greedy in-order split needs no more than day_limit groups.
// ----------------------------------------------------------------------------
//  channel   direction  fields (lsb first)            handshake
//  s_*       in         tdata: weight, tlast: last    s_tvalid & s_tready
//  m_*       out        tdata: min_capacity           m_tvalid & m_tready
//  cfg_*     in         cfg_data: day_limit           cfg_valid & cfg_ready
//
//  loading takes one cycle per item; s_tready is high only while loading
//  after the last item: a prepare state and a divider for the lower bound,
//  then per search step a midpoint state and a scan, one stored weight read
//  per cycle from the single memory read port; about log2(total) steps
//  the result is held until m_tready; the run then clears for the next one
//  reset clears counters, totals and day_limit (to 1); the store is not cleared
// ----------------------------------------------------------------------------
module min_capacity_partition_search_unit
    import mcps_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // weight
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,   // min_capacity
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [DAY_BITS-1:0]      cfg_data
);

    localparam logic [CNT_BITS-1:0]  MAX_CNT  = CNT_BITS'(MAX_ITEMS);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(NUM_BITS - 1);

    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [CAP_BITS-1:0]    total_reg, total_next;
    logic [WEIGHT_BITS-1:0] wmax_reg, wmax_next;
    logic [DAY_BITS-1:0]    days_reg, days_next;
    logic [NUM_BITS-1:0]    num_reg, num_next;
    logic [DAY_BITS-1:0]    rem_reg, rem_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic [CAP_BITS-1:0]    lo_reg, lo_next;
    logic [CAP_BITS-1:0]    hi_reg, hi_next;
    logic [CAP_BITS-1:0]    mid_reg, mid_next;
    logic [CNT_BITS-1:0]    idx_reg, idx_next;
    logic                   pend_reg, pend_next;
    logic [CAP_BITS-1:0]    acc_reg, acc_next;
    logic [DAY_BITS-1:0]    grp_reg, grp_next;

    logic [WEIGHT_BITS-1:0] mem [MAX_ITEMS];
    logic [WEIGHT_BITS-1:0] mem_q;
    logic                   wr_en;
    logic                   rd_en;

    logic [DAY_BITS-1:0]    days_eff;
    logic [DAY_BITS:0]      rem_sh;
    logic [NUM_BITS-1:0]    sum;
    logic [DAY_BITS-1:0]    grp_inc;
    logic [WEIGHT_BITS-1:0] w_in;

    assign w_in      = s_tdata[WEIGHT_BITS-1:0];
    assign days_eff  = (days_reg == '0) ? DAY_BITS'(1) : days_reg;
    assign rem_sh    = {rem_reg, num_reg[NUM_BITS-1]};
    assign sum       = {1'b0, acc_reg} + NUM_BITS'(mem_q);
    assign grp_inc   = grp_reg + DAY_BITS'(1);
    assign cfg_ready = 1'b1;
    assign m_tdata   = OUT_DATA_BITS'(lo_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        total_next = total_reg;
        wmax_next  = wmax_reg;
        days_next  = cfg_valid ? cfg_data : days_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        acc_next   = acc_reg;
        grp_next   = grp_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (cnt_reg < MAX_CNT)
                    begin
                        wr_en      = 1'b1;
                        cnt_next   = cnt_reg + CNT_BITS'(1);
                        total_next = total_reg + CAP_BITS'(w_in);
                        if (w_in > wmax_reg)
                        begin
                            wmax_next = w_in;
                        end
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                // ceiling division: divide total + days - 1
                num_next   = NUM_BITS'(total_reg) + NUM_BITS'(days_eff - DAY_BITS'(1));
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (rem_sh >= {1'b0, days_eff})
                begin
                    rem_next = DAY_BITS'(rem_sh - {1'b0, days_eff});
                    num_next = {num_reg[NUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[DAY_BITS-1:0];
                    num_next = {num_reg[NUM_BITS-2:0], 1'b0};
                end
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_BOUND;
                end
            end
            ST_BOUND:
            begin
                hi_next = total_reg;
                if (CAP_BITS'(wmax_reg) > num_reg[CAP_BITS-1:0])
                begin
                    lo_next = CAP_BITS'(wmax_reg);
                end
                else
                begin
                    lo_next = num_reg[CAP_BITS-1:0];
                end
                state_next = ST_MID;
            end
            ST_MID:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = CAP_BITS'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
                    idx_next   = '0;
                    acc_next   = '0;
                    grp_next   = DAY_BITS'(1);
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_SCAN:
            begin
                rd_en     = idx_reg < cnt_reg;
                pend_next = rd_en;
                if (rd_en)
                begin
                    idx_next = idx_reg + CNT_BITS'(1);
                end
                if (pend_reg)
                begin
                    if (sum > {1'b0, mid_reg})
                    begin
                        grp_next = grp_inc;
                        acc_next = CAP_BITS'(mem_q);
                        if (grp_inc > days_eff)
                        begin
                            // too many groups: capacity too small
                            lo_next    = mid_reg + CAP_BITS'(1);
                            state_next = ST_MID;
                        end
                    end
                    else
                    begin
                        acc_next = sum[CAP_BITS-1:0];
                    end
                end
                else if (!rd_en)
                begin
                    if (grp_reg <= days_eff)
                    begin
                        hi_next = mid_reg;
                    end
                    else
                    begin
                        lo_next = mid_reg + CAP_BITS'(1);
                    end
                    state_next = ST_MID;
                end
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    cnt_next   = '0;
                    total_next = '0;
                    wmax_next  = '0;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            total_reg <= '0;
            wmax_reg  <= '0;
            days_reg  <= DAY_BITS'(1);
            step_reg  <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            grp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
            wmax_reg  <= wmax_next;
            days_reg  <= days_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            grp_reg   <= grp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        acc_reg <= acc_next;
    end

    // weight store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_reg[ADDR_BITS-1:0]] <= w_in;
        end
        if (rd_en)
        begin
            mem_q <= mem[idx_reg[ADDR_BITS-1:0]];
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT)
        else $error("item count above store depth");

    a_mid_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (lo_reg <= mid_reg && mid_reg < hi_reg))
        else $error("candidate outside search interval");

    a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (lo_reg >= CAP_BITS'(wmax_reg) && lo_reg <= total_reg))
        else $error("result outside weight bounds");

    a_grp_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (grp_reg <= days_eff))
        else $error("scan continued past day limit");

endmodule
